// ----- src/trb_pkg.sv -----
// ----------------------------------------------------------------------------
// trb_pkg
// Shared constants and types for the transfer ring producer.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int RING_ENTRIES_DEF = 256;

    localparam int ADDR_W    = 64;
    localparam int WORD_W    = 32;
    localparam int LEN_W     = 21;
    localparam int CHUNK_W   = 17;
    localparam int SLOT_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [24:0] MAX_LENGTH = 25'd1048576;
    localparam logic [CHUNK_W-1:0] SEG_SIZE = 17'h10000;

    localparam logic [WORD_W-1:0] CTRL_LINK_TYPE = 32'(6) << 10;
    localparam logic [WORD_W-1:0] CTRL_TOGGLE    = 32'h0000_0002;
    localparam logic [WORD_W-1:0] CTRL_CHAIN     = 32'h0000_0010;
    localparam logic [WORD_W-1:0] CTRL_CYCLE     = 32'h0000_0001;

    localparam logic [1:0] MODE_REINIT = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_SPLIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_CHAIN = 8'd1;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic               done;
        logic [ADDR_W-1:0]  addr_next;
        logic [LEN_W-1:0]   left_next;
    } seg_result_t;

endpackage

// ----- src/trb_ring_producer_unit.sv -----
// ----------------------------------------------------------------------------
// trb_ring_producer_unit
// Producer side of a transfer descriptor ring with link wrap handling.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes ring_base_address (index 0) and link_chain_bit
//   (index 1) while idle; cfg_ready is always high.
//   in channel takes one request: mode 0 reinit, 1 single descriptor,
//   2 split buffer. The block drops in_ready until the request is done.
//   out channel delivers one descriptor write per item; last_write marks
//   the final write of a request, which may be a link rewrite.
// Timing:
//   A request is accepted, then a sequencer emits one write per cycle
//   while the output register is free, through a single segment step
//   unit (boundary, clip, add). Mode 0 writes one link, mode 1 one
//   descriptor plus a link at the wrap, mode 2 up to about 17 pieces
//   plus links. Empty, oversized and unused-mode requests emit nothing.
// Stall: the output register holds a result until out_ready; the
//   sequencer waits on it. A new request may be accepted while the last
//   result of the previous one still waits.
// Reset: index 0, cycle bit 1, config registers 0, no result pending.
// ----------------------------------------------------------------------------
module trb_ring_producer_unit
    import trb_pkg::*;
#(
    parameter int RING_ENTRIES = RING_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [ADDR_W-1:0]    param_word,
    input  logic [WORD_W-1:0]    status_word,
    input  logic [LEN_W-1:0]     buffer_length,
    input  logic [WORD_W-1:0]    control_word,
    input  logic [WORD_W-1:0]    tail_control,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SLOT_W-1:0]    entry_index,
    output logic [ADDR_W-1:0]    trb_parameter,
    output logic [WORD_W-1:0]    trb_status,
    output logic [WORD_W-1:0]    desc_control,
    output logic                 is_link,
    output logic                 last_write
);

    localparam int IDX_W = $clog2(RING_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_ENTRIES - 1);
    localparam logic [IDX_W-1:0] WRAP_SLOT = IDX_W'(RING_ENTRIES - 2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PUT  = 3'b010,
        ST_LINK = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               cycle_reg, cycle_next;
    logic [ADDR_W-1:0]  base_reg;
    logic               chain_reg;
    logic               toggle_reg, toggle_next;
    logic               link_last_reg, link_last_next;

    logic               split_reg, split_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [WORD_W-1:0]  sts_reg, sts_next;
    logic [WORD_W-1:0]  ctl_reg, ctl_next;
    logic [WORD_W-1:0]  fin_reg, fin_next;

    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_idx_reg, out_idx_next;
    logic [ADDR_W-1:0]  out_par_reg, out_par_next;
    logic [WORD_W-1:0]  out_sts_reg, out_sts_next;
    logic [WORD_W-1:0]  out_ctl_reg, out_ctl_next;
    logic               out_link_reg, out_link_next;
    logic               out_last_reg, out_last_next;

    logic               slot_free;
    logic               emit;
    logic               piece_done;
    logic               wrap;
    logic               len_ok;
    logic [WORD_W-1:0]  link_ctl;
    seg_result_t        seg;

    trb_seg_step u_seg_step (
        .addr (addr_reg),
        .left (left_reg),
        .res  (seg)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    assign len_ok   = (buffer_length != '0) && (25'(buffer_length) <= MAX_LENGTH);
    assign link_ctl = CTRL_LINK_TYPE | CTRL_TOGGLE | (chain_reg ? CTRL_CHAIN : '0)
                    | (cycle_reg ? CTRL_CYCLE : '0);
    assign piece_done = !split_reg || seg.done;
    assign wrap       = (idx_reg == WRAP_SLOT);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cycle_next     = cycle_reg;
        toggle_next    = toggle_reg;
        link_last_next = link_last_reg;
        split_next     = split_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        sts_next       = sts_reg;
        ctl_next       = ctl_reg;
        fin_next       = fin_reg;
        emit           = 1'b0;
        out_idx_next   = out_idx_reg;
        out_par_next   = out_par_reg;
        out_sts_next   = out_sts_reg;
        out_ctl_next   = out_ctl_reg;
        out_link_next  = out_link_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_REINIT:
                        begin
                            idx_next       = '0;
                            cycle_next     = 1'b1;
                            toggle_next    = 1'b0;
                            link_last_next = 1'b1;
                            state_next     = ST_LINK;
                        end
                        MODE_SINGLE:
                        begin
                            split_next = 1'b0;
                            addr_next  = param_word;
                            sts_next   = status_word;
                            ctl_next   = control_word;
                            state_next = ST_PUT;
                        end
                        MODE_SPLIT:
                        begin
                            if (len_ok)
                            begin
                                split_next = 1'b1;
                                addr_next  = param_word;
                                left_next  = buffer_length;
                                ctl_next   = control_word;
                                fin_next   = tail_control;
                                state_next = ST_PUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    out_idx_next  = SLOT_W'(idx_reg);
                    out_par_next  = addr_reg;
                    out_link_next = 1'b0;
                    out_last_next = piece_done && !wrap;
                    if (split_reg)
                    begin
                        out_sts_next = WORD_W'(seg.chunk);
                        out_ctl_next = ctl_reg | (seg.done ? fin_reg : CTRL_CHAIN);
                    end
                    else
                    begin
                        out_sts_next = sts_reg;
                        out_ctl_next = ctl_reg;
                    end
                    out_ctl_next = out_ctl_next | (cycle_reg ? CTRL_CYCLE : '0);
                    addr_next    = seg.addr_next;
                    left_next    = seg.left_next;
                    if (wrap)
                    begin
                        idx_next       = '0;
                        toggle_next    = 1'b1;
                        link_last_next = piece_done;
                        state_next     = ST_LINK;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        if (piece_done)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_LINK:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    out_idx_next  = SLOT_W'(LAST_SLOT);
                    out_par_next  = base_reg;
                    out_sts_next  = '0;
                    out_ctl_next  = link_ctl;
                    out_link_next = 1'b1;
                    out_last_next = link_last_reg;
                    cycle_next    = cycle_reg ^ toggle_reg;
                    state_next    = link_last_reg ? ST_IDLE : ST_PUT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cycle_reg     <= 1'b1;
            toggle_reg    <= 1'b0;
            link_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            chain_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cycle_reg     <= cycle_next;
            toggle_reg    <= toggle_next;
            link_last_reg <= link_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_index == CFG_RING_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_LINK_CHAIN)
            begin
                chain_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        sts_reg   <= sts_next;
        ctl_reg   <= ctl_next;
        fin_reg   <= fin_next;
        if (emit)
        begin
            out_idx_reg  <= out_idx_next;
            out_par_reg  <= out_par_next;
            out_sts_reg  <= out_sts_next;
            out_ctl_reg  <= out_ctl_next;
            out_link_reg <= out_link_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_index   = out_idx_reg;
    assign trb_parameter = out_par_reg;
    assign trb_status    = out_sts_reg;
    assign desc_control  = out_ctl_reg;
    assign is_link       = out_link_reg;
    assign last_write    = out_last_reg;

    a_link_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_link |-> entry_index == SLOT_W'(LAST_SLOT))
        else $error("link write not at last slot");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != LAST_SLOT)
        else $error("enqueue index reached link slot");

    a_cycle_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && state_reg == ST_LINK && toggle_reg |=> cycle_reg != $past(cycle_reg))
        else $error("cycle bit did not toggle on wrap");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !in_ready)
        else $error("request accepted while emitting");

endmodule

// ----- src/trb_seg_step.sv -----
// ----------------------------------------------------------------------------
// trb_seg_step
// One buffer split step: piece length up to the next 64 KiB boundary,
// clipped to the bytes left, with the advanced address and remainder.
// ----------------------------------------------------------------------------
module trb_seg_step
    import trb_pkg::*;
(
    input  logic [ADDR_W-1:0] addr,
    input  logic [LEN_W-1:0]  left,
    output seg_result_t       res
);

    logic [CHUNK_W-1:0] to_boundary;
    logic               fits;

    always_comb
    begin
        to_boundary   = SEG_SIZE - {1'b0, addr[15:0]};
        fits          = LEN_W'(to_boundary) >= left;
        res.done      = fits;
        res.chunk     = fits ? CHUNK_W'(left) : to_boundary;
        res.addr_next = addr + ADDR_W'(res.chunk);
        res.left_next = left - LEN_W'(res.chunk);
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transfer ring producer.
// Sends reinit, single and split requests with random gaps and output back
// pressure. Ring writes are predicted from the enqueue index, cycle bit and
// link settings or a row's known write, then compared in order at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import trb_pkg::*;

    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;
    localparam int                   SIDE_SEND    = 0;
    localparam int                   SIDE_RECV    = 1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] param;
        logic [WORD_W-1:0] status;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] ctl;
        logic [WORD_W-1:0] fin;
    } trb_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] par;
        logic [WORD_W-1:0] sts;
        logic [WORD_W-1:0] ctl;
        logic              link;
        logic              last;
    } trb_write_t;

    typedef struct packed {
        trb_req_t   req;
        logic       has_known;
        trb_write_t known;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           mode;
    logic [ADDR_W-1:0]    param_word;
    logic [WORD_W-1:0]    status_word;
    logic [LEN_W-1:0]     buffer_length;
    logic [WORD_W-1:0]    control_word;
    logic [WORD_W-1:0]    tail_control;
    logic                 out_valid;
    logic                 out_ready;
    logic [SLOT_W-1:0]    entry_index;
    logic [ADDR_W-1:0]    trb_parameter;
    logic [WORD_W-1:0]    trb_status;
    logic [WORD_W-1:0]    desc_control;
    logic                 is_link;
    logic                 last_write;

    // predicted ring state
    logic [ADDR_W-1:0] ring_base_q;
    logic              link_chain_q;
    int                enq_slot;
    logic              prod_cycle;

    trb_write_t req_writes[$];
    trb_write_t pending_writes[$];
    dir_row_t   directed_rows[$];

    int quiet_left[2];
    int mismatches;
    int reqs_sent;
    int writes_checked;
    int link_writes;
    int reg_writes;

    trb_ring_producer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .param_word    (param_word),
        .status_word   (status_word),
        .buffer_length (buffer_length),
        .control_word  (control_word),
        .tail_control  (tail_control),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entry_index   (entry_index),
        .trb_parameter (trb_parameter),
        .trb_status    (trb_status),
        .desc_control  (desc_control),
        .is_link       (is_link),
        .last_write    (last_write)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic trb_req_t mk_req(logic [1:0] m, logic [ADDR_W-1:0] p,
                                        logic [WORD_W-1:0] s, logic [LEN_W-1:0] l,
                                        logic [WORD_W-1:0] c, logic [WORD_W-1:0] f);
        trb_req_t r;
        r.mode   = m;
        r.param  = p;
        r.status = s;
        r.len    = l;
        r.ctl    = c;
        r.fin    = f;
        return r;
    endfunction

    function automatic trb_write_t mk_wr(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] par,
                                         logic [WORD_W-1:0] sts, logic [WORD_W-1:0] ctl,
                                         logic link, logic last);
        trb_write_t w;
        w.slot = slot;
        w.par  = par;
        w.sts  = sts;
        w.ctl  = ctl;
        w.link = link;
        w.last = last;
        return w;
    endfunction

    function automatic void add_row(trb_req_t r, logic has_known, trb_write_t known);
        dir_row_t row;
        row.req       = r;
        row.has_known = has_known;
        row.known     = known;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [WORD_W-1:0] link_word();
        return CTRL_LINK_TYPE | CTRL_TOGGLE | (link_chain_q ? CTRL_CHAIN : 32'h0)
               | {31'h0, prod_cycle};
    endfunction

    function automatic void place_trb(logic [ADDR_W-1:0] par, logic [WORD_W-1:0] sts,
                                      logic [WORD_W-1:0] ctl);
        req_writes.push_back(mk_wr(enq_slot[SLOT_W-1:0], par, sts,
                                   ctl | {31'h0, prod_cycle}, 1'b0, 1'b0));
        enq_slot++;
        if (enq_slot >= RING_ENTRIES_DEF - 1)
        begin
            req_writes.push_back(mk_wr(SLOT_W'(RING_ENTRIES_DEF - 1), ring_base_q, '0,
                                       link_word(), 1'b1, 1'b0));
            enq_slot   = 0;
            prod_cycle = ~prod_cycle;
        end
    endfunction

    function automatic void predict_ring_writes(trb_req_t r);
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] piece;
        logic [WORD_W-1:0] c;
        trb_write_t        w;
        req_writes.delete();
        case (r.mode)
            MODE_REINIT:
            begin
                enq_slot   = 0;
                prod_cycle = 1'b1;
                req_writes.push_back(mk_wr(SLOT_W'(RING_ENTRIES_DEF - 1), ring_base_q, '0,
                                           link_word(), 1'b1, 1'b0));
            end
            MODE_SINGLE:
                place_trb(r.param, r.status, r.ctl);
            MODE_SPLIT:
            begin
                if (r.len != '0 && 25'(r.len) <= MAX_LENGTH)
                begin
                    addr = r.param;
                    left = 32'(r.len);
                    while (left != 0)
                    begin
                        piece = 32'h10000 - 32'(addr[15:0]);
                        if (piece > left)
                            piece = left;
                        c = (piece < left) ? (r.ctl | CTRL_CHAIN) : (r.ctl | r.fin);
                        place_trb(addr, piece, c);
                        addr = addr + 64'(piece);
                        left = left - piece;
                    end
                end
            end
            default:
                ;
        endcase
        if (req_writes.size() > 0)
        begin
            w = req_writes.pop_back();
            w.last = 1'b1;
            req_writes.push_back(w);
        end
    endfunction

    // runs of zero gaps now and then, otherwise a random gap per item
    function automatic int draw_gap(int side);
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            quiet_left[side] = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic trb_req_t rand_req();
        trb_req_t r;
        int       pick;
        r.param  = {$urandom, $urandom};
        r.status = $urandom;
        r.len    = LEN_W'($urandom);
        r.ctl    = $urandom;
        r.fin    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            r.mode = MODE_REINIT;
        else if (pick < 5)
            r.mode = MODE_UNUSED;
        else if (pick < 35)
            r.mode = MODE_SINGLE;
        else
        begin
            r.mode = MODE_SPLIT;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                r.len = '0;
            else if (pick < 10)
                r.len = LEN_W'($urandom_range(32'd1048577, 32'd2097151));
            else if (pick < 16)
                r.len = LEN_W'(MAX_LENGTH);
            else if (pick < 25)
                r.len = LEN_W'($urandom_range(32'h80000, 32'hFFFFF));
            else
                r.len = LEN_W'($urandom_range(1, 32'h2FFFF));
            if ($urandom_range(0, 9) == 0)
                r.param[63:20] = '1;
            if ($urandom_range(0, 7) == 0)
                r.param[15:0] = '0;
        end
        return r;
    endfunction

    task automatic send_req(trb_req_t r, logic has_known, trb_write_t known);
        int gap;
        gap = draw_gap(SIDE_SEND);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode          <= r.mode;
        param_word    <= r.param;
        status_word   <= r.status;
        buffer_length <= r.len;
        control_word  <= r.ctl;
        tail_control  <= r.fin;
        in_valid      <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_ring_writes(r);
        if (has_known)
        begin
            req_writes.delete();
            req_writes.push_back(known);
        end
        foreach (req_writes[i])
            pending_writes.push_back(req_writes[i]);
        reqs_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_RING_BASE)
            ring_base_q = val;
        else if (idx == CFG_LINK_CHAIN)
            link_chain_q = val[0];
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count) send_req(rand_req(), 1'b0, '0);
    endtask

    task automatic wait_ring_idle();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int gap;
        int taken;
        taken = 0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = draw_gap(SIDE_RECV);
            // long hold-off so the block backs up into its input
            if (taken == 80 || taken == 300)
                gap = 400;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        trb_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected item: slot %0d, parameter %h", entry_index, trb_parameter);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (entry_index !== want.slot)
                begin
                    $error("entry_index: expected %0d, got %0d", want.slot, entry_index);
                    mismatches++;
                end
                if (trb_parameter !== want.par)
                begin
                    $error("trb_parameter: expected %h, got %h", want.par, trb_parameter);
                    mismatches++;
                end
                if (trb_status !== want.sts)
                begin
                    $error("trb_status: expected %h, got %h", want.sts, trb_status);
                    mismatches++;
                end
                if (desc_control !== want.ctl)
                begin
                    $error("desc_control: expected %h, got %h", want.ctl, desc_control);
                    mismatches++;
                end
                if (is_link !== want.link)
                begin
                    $error("is_link: expected %0b, got %0b", want.link, is_link);
                    mismatches++;
                end
                if (last_write !== want.last)
                begin
                    $error("last_write: expected %0b, got %0b", want.last, last_write);
                    mismatches++;
                end
                if (want.link)
                    link_writes++;
                writes_checked++;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $error("timeout with %0d writes still expected", pending_writes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        mode          <= MODE_REINIT;
        param_word    <= '0;
        status_word   <= '0;
        buffer_length <= '0;
        control_word  <= '0;
        tail_control  <= '0;
        ring_base_q    = '0;
        link_chain_q   = 1'b0;
        enq_slot       = 0;
        prod_cycle     = 1'b1;
        mismatches     = 0;
        reqs_sent      = 0;
        writes_checked = 0;
        link_writes    = 0;
        reg_writes     = 0;
        quiet_left[SIDE_SEND] = 0;
        quiet_left[SIDE_RECV] = 0;

        // rows with a known write assume base 0, no link chain
        add_row(mk_req(MODE_REINIT, '0, '0, '0, '0, '0), 1'b1,
                mk_wr(8'hFF, '0, '0, 32'h0000_1803, 1'b1, 1'b1));
        add_row(mk_req(MODE_SINGLE, '1, '1, '0, '0, '1), 1'b1,
                mk_wr(8'h00, '1, '1, 32'h0000_0001, 1'b0, 1'b1));
        add_row(mk_req(MODE_SINGLE, '0, '0, '0, '1, '0), 1'b1,
                mk_wr(8'h01, '0, '0, '1, 1'b0, 1'b1));
        add_row(mk_req(MODE_SPLIT, '1, '1, '0, '1, '1), 1'b0, '0);
        add_row(mk_req(MODE_SPLIT, 64'h0000_0000_0001_0000, '0, 21'd1048577, '0, '0),
                1'b0, '0);
        add_row(mk_req(MODE_SPLIT, '0, '0, '1, '0, '0), 1'b0, '0);
        add_row(mk_req(MODE_UNUSED, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(mk_req(MODE_SPLIT, '0, '0, 21'd1, '0, 32'h0000_0020), 1'b1,
                mk_wr(8'h02, '0, 32'd1, 32'h0000_0021, 1'b0, 1'b1));
        add_row(mk_req(MODE_SPLIT, 64'h1234_5678_0000_0000, '0, 21'h10000,
                       32'h0000_0400, 32'h0000_0020), 1'b1,
                mk_wr(8'h03, 64'h1234_5678_0000_0000, 32'h0001_0000, 32'h0000_0421,
                      1'b0, 1'b1));
        add_row(mk_req(MODE_SPLIT, '0, '0, LEN_W'(MAX_LENGTH), 32'h0000_0C00,
                       32'h0000_0020), 1'b0, '0);
        add_row(mk_req(MODE_SPLIT, 64'hFFFF_FFFF_FFFF_8001, '0, LEN_W'(MAX_LENGTH),
                       32'h1234_5600, 32'hFFFF_FFFE), 1'b0, '0);
        add_row(mk_req(MODE_SPLIT, 64'h00AB_CDEF_0123_FFFF, '0, 21'd2, '0, '0), 1'b0, '0);
        add_row(mk_req(MODE_SINGLE, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, '0,
                       32'h0000_0001, '0), 1'b0, '0);
        add_row(mk_req(MODE_REINIT, '1, '1, '1, '1, '1), 1'b1,
                mk_wr(8'hFF, '0, '0, 32'h0000_1803, 1'b1, 1'b1));
        add_row(mk_req(MODE_SINGLE, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, '0,
                       32'h0000_2400, '0), 1'b1,
                mk_wr(8'h00, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_2401,
                      1'b0, 1'b1));
        add_row(mk_req(MODE_SPLIT, 64'h8000_0000_0000_FFF0, '0, 21'h1FFFF, '1, '0),
                1'b0, '0);
        add_row(mk_req(MODE_UNUSED, '0, '0, '0, '0, '0), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_RING_BASE, '0);
        write_reg(CFG_LINK_CHAIN, '0);
        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].has_known,
                     directed_rows[i].known);
        wait_ring_idle();

        write_reg(CFG_RING_BASE, '1);
        write_reg(CFG_LINK_CHAIN, 64'd1);
        run_random(36);
        wait_ring_idle();

        write_reg(CFG_RING_BASE, {$urandom, $urandom});
        write_reg(CFG_LINK_CHAIN, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_UNMAPPED, '1);
        run_random(36);
        wait_ring_idle();

        write_reg(CFG_LINK_CHAIN, 64'd1);
        write_reg(CFG_RING_BASE, {$urandom, $urandom});
        run_random(36);
        wait_ring_idle();

        write_reg(CFG_RING_BASE, '0);
        write_reg(CFG_LINK_CHAIN, '0);
        run_random(36);
        wait_ring_idle();

        repeat (40) @(posedge clk);
        $display("Sent %0d requests and %0d register writes across five link settings.",
                 reqs_sent, reg_writes);
        $display("Checked %0d descriptor writes, %0d of them link writes; %0d mismatches.",
                 writes_checked, link_writes, mismatches);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- trb_ring_producer_unit.f -----
src/trb_pkg.sv
src/trb_seg_step.sv
src/trb_ring_producer_unit.sv
dv/tb_top.sv
